// File: hdl/decimal_to_best_fraction_assert.svh
// Assertion macros used by the checker file of decimal_to_best_fraction.
// No dependencies; included by bare file name.
`ifndef DECIMAL_TO_BEST_FRACTION_ASSERT_SVH
`define DECIMAL_TO_BEST_FRACTION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTBF_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DTBF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/dtbf_pkg.sv
// Package for decimal_to_best_fraction: field widths, search limits.
// No dependencies.
package dtbf_pkg;

	// numerator/denominator, test value, product and count widths
	localparam int ND_W  = 17;
	localparam int T_W   = 50;
	localparam int PRD_W = 49;
	localparam int CNT_W = 17;

	localparam logic [ND_W-1:0] NUM_LIMIT_EVEN = 17'h10000;
	localparam logic [ND_W-1:0] NUM_LIMIT_ODD  = 17'h08000;
	localparam logic [ND_W-1:0] DEN_LIMIT      = 17'h10000;

	typedef logic [ND_W-1:0] nd_t;
	typedef logic [T_W-1:0]  tval_t;

endpackage

// File: hdl/dtbf_mul.sv
// Shared 32x17 multiplier with registered product.
// Depends on dtbf_pkg.
module dtbf_mul (
	input  logic                       clk,
	input  logic [31:0]                a,
	input  logic [dtbf_pkg::ND_W-1:0]  b,
	output logic [dtbf_pkg::PRD_W-1:0] prod
);

	logic [dtbf_pkg::PRD_W-1:0] prod_q;

	// product register, no reset needed on payload
	always_ff @(posedge clk) begin
		prod_q <= dtbf_pkg::PRD_W'(a) * dtbf_pkg::PRD_W'(b);
	end

	assign prod = prod_q;

endmodule

// File: hdl/dtbf_div.sv
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
// Caller guarantees dividend < divisor * 2^17. Depends on dtbf_pkg.
module dtbf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  dtbf_pkg::tval_t            dividend,
	input  dtbf_pkg::tval_t            divisor,
	output logic                       done,
	output logic [dtbf_pkg::CNT_W-1:0] quot
);

	localparam int W = dtbf_pkg::T_W + dtbf_pkg::CNT_W;

	logic                       busy_q;
	logic [4:0]                 k_q;
	dtbf_pkg::tval_t            rem_q;
	dtbf_pkg::tval_t            dvs_q;
	logic [dtbf_pkg::CNT_W-1:0] quot_q;
	logic [W-1:0]               shifted;
	logic                       fits;

	// trial subtract of divisor shifted by current bit position
	always_comb begin
		shifted = W'(dvs_q) << k_q;
		fits    = W'(rem_q) >= shifted;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			k_q    <= 5'(dtbf_pkg::CNT_W - 1);
		end else if (busy_q) begin
			if (k_q == 5'd0) begin
				busy_q <= 1'b0;
			end
			k_q <= k_q - 5'd1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dvs_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dtbf_pkg::T_W'(shifted);
			end
			quot_q <= {quot_q[dtbf_pkg::CNT_W-2:0], fits};
		end
	end

	assign done = busy_q && (k_q == 5'd0);
	assign quot = {quot_q[dtbf_pkg::CNT_W-2:0], fits};

endmodule

// File: hdl/decimal_to_best_fraction.sv
// Top level of decimal_to_best_fraction: sequencer, bounds, output hold.
// Depends on dtbf_pkg, dtbf_mul, dtbf_div.
//
// Converts a signed fixed-point value into a truncated whole part and the
// closest fraction num/den (den <= 65536) to the remainder within tolerance,
// by alternating mediant bracketing steps. One item at a time: in_stall is
// high from acceptance until the result is taken. Each bracketing step forms
// the test products in the shared multiplier, checks them, runs the
// bit-serial divider and forms the new bound with further products; there
// are at most MAX_STEPS steps per item, and a new item is taken only once
// the last result has been taken. A negative value with a nonzero fraction
// gives 0/1 with no bracketing steps.
module decimal_to_best_fraction #(
	parameter int MAX_STEPS = 100,
	parameter int FRAC_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] whole_part,
	output logic [16:0] frac_numerator,
	output logic [16:0] frac_denominator,
	input  logic        tolerance_we,
	input  logic [31:0] tolerance_wdata
);

	localparam int STEP_W = $clog2(MAX_STEPS + 1);
	localparam int ND_W   = dtbf_pkg::ND_W;
	localparam int T_W    = dtbf_pkg::T_W;
	localparam int CW     = T_W + dtbf_pkg::CNT_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MLO  = 4'd1;
	localparam logic [3:0] ST_MHI  = 4'd2;
	localparam logic [3:0] ST_TOLH = 4'd3;
	localparam logic [3:0] ST_TOLL = 4'd4;
	localparam logic [3:0] ST_CHK  = 4'd5;
	localparam logic [3:0] ST_DIV  = 4'd6;
	localparam logic [3:0] ST_NUM  = 4'd7;
	localparam logic [3:0] ST_DEN  = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic [3:0]               state_q;
	logic [31:0]              tol_q;
	logic [31:0]              rem_q;
	logic [31:0]              whole_q;
	dtbf_pkg::nd_t            lo_n_q, lo_d_q, hi_n_q, hi_d_q;
	dtbf_pkg::tval_t          tlo_q, thi_q, num_q;
	dtbf_pkg::nd_t            cnt1_q;
	logic [STEP_W-1:0]        step_q;

	logic [31:0]                mul_a;
	dtbf_pkg::nd_t              mul_b;
	logic [dtbf_pkg::PRD_W-1:0] prod;
	logic                       div_start, div_done;
	logic [dtbf_pkg::CNT_W-1:0] quot;

	logic                       odd;
	dtbf_pkg::tval_t            dvd, dvs, prod_t, den;
	logic                       ovf;
	logic                       neg;
	logic [63:0]                mag, fmask, q;
	logic [31:0]                frac32;
	dtbf_pkg::nd_t              num_lim;

	// input split
	always_comb begin
		neg    = value[63];
		mag    = neg ? (64'd0 - value) : value;
		fmask  = (64'd1 << FRAC_BITS) - 64'd1;
		q      = mag >> FRAC_BITS;
		frac32 = 32'(mag & fmask);
	end

	// step operands and checks
	always_comb begin
		odd     = step_q[0];
		dvd     = odd ? thi_q : tlo_q;
		dvs     = odd ? tlo_q : thi_q;
		prod_t  = T_W'(prod);
		ovf     = CW'(dvd) >= (CW'(dvs) << dtbf_pkg::CNT_W);
		den     = prod_t + T_W'(odd ? hi_d_q : lo_d_q);
		num_lim = odd ? dtbf_pkg::NUM_LIMIT_ODD : dtbf_pkg::NUM_LIMIT_EVEN;
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MLO: begin
				mul_a = rem_q;
				mul_b = lo_d_q;
			end
			ST_MHI: begin
				mul_a = rem_q;
				mul_b = hi_d_q;
			end
			ST_TOLH: begin
				mul_a = tol_q;
				mul_b = hi_d_q;
			end
			ST_TOLL: begin
				mul_a = tol_q;
				mul_b = lo_d_q;
			end
			ST_DIV: begin
				mul_a = 32'(ND_W'(quot + 17'd1));
				mul_b = odd ? lo_n_q : hi_n_q;
			end
			ST_NUM: begin
				mul_a = 32'(cnt1_q);
				mul_b = odd ? lo_d_q : hi_d_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_start = (state_q == ST_CHK) && !(tlo_q < prod_t) && (dvs != '0) && !ovf;

	dtbf_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	dtbf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quot     (quot)
	);

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 32'd4295;
		end else if (tolerance_we) begin
			tol_q <= tolerance_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						step_q  <= '0;
						state_q <= (neg && frac32 != 32'd0) ? ST_OUT : ST_MLO;
					end
				end
				ST_MLO:  state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_TOLH;
				ST_TOLH: state_q <= ST_TOLL;
				ST_TOLL: state_q <= (thi_q < prod_t) ? ST_OUT : ST_CHK;
				ST_CHK:  state_q <= div_start ? ST_DIV : ST_OUT;
				ST_DIV: begin
					if (div_done) begin
						state_q <= (quot > dtbf_pkg::DEN_LIMIT) ? ST_OUT : ST_NUM;
					end
				end
				ST_NUM:  state_q <= ST_DEN;
				ST_DEN: begin
					if (num_q > T_W'(num_lim) || den > T_W'(dtbf_pkg::DEN_LIMIT) ||
					    step_q == STEP_W'(MAX_STEPS - 1)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_MLO;
					end
					step_q <= step_q + 1'b1;
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// bounds and test values
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				whole_q <= 32'(neg ? (64'd0 - q) : q);
				rem_q   <= frac32 << (32 - FRAC_BITS);
				lo_n_q  <= '0;
				lo_d_q  <= ND_W'(1);
				hi_d_q  <= ND_W'(1);
				hi_n_q  <= (neg && frac32 != 32'd0) ? '0 : ND_W'(1);
			end
			ST_MHI: tlo_q <= prod_t - {1'b0, lo_n_q, 32'd0};
			ST_TOLH: thi_q <= {1'b0, hi_n_q, 32'd0} - prod_t;
			ST_CHK: begin
				if (tlo_q < prod_t) begin
					hi_n_q <= lo_n_q;
					hi_d_q <= lo_d_q;
				end
			end
			ST_DIV: cnt1_q <= ND_W'(quot + 17'd1);
			ST_NUM: num_q <= prod_t + T_W'(odd ? hi_n_q : lo_n_q);
			ST_DEN: begin
				if (!(num_q > T_W'(num_lim) || den > T_W'(dtbf_pkg::DEN_LIMIT))) begin
					if (odd) begin
						hi_n_q <= ND_W'(num_q) - lo_n_q;
						hi_d_q <= ND_W'(den) - lo_d_q;
						lo_n_q <= ND_W'(num_q);
						lo_d_q <= ND_W'(den);
					end else begin
						lo_n_q <= ND_W'(num_q) - hi_n_q;
						lo_d_q <= ND_W'(den) - hi_d_q;
						hi_n_q <= ND_W'(num_q);
						hi_d_q <= ND_W'(den);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall         = (state_q != ST_IDLE);
	assign out_valid        = (state_q == ST_OUT);
	assign whole_part       = whole_q;
	assign frac_numerator   = hi_n_q;
	assign frac_denominator = hi_d_q;

endmodule

// File: hdl/dtbf_chk.sv
// Port checker for decimal_to_best_fraction, bound to the top level.
// Depends on decimal_to_best_fraction_assert.svh.
`include "decimal_to_best_fraction_assert.svh"

module dtbf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [16:0] frac_numerator,
	input logic [16:0] frac_denominator
);

	// a result waits until taken
	`DTBF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	// an accepted item makes the block busy
	`DTBF_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	// no item taken while a result is pending
	`DTBF_ASSERT_NOW(a_one_item, clk, arst_n, out_valid, in_stall)
	// fraction numerator does not exceed a nonzero denominator
	`DTBF_ASSERT_NOW(a_frac_ok, clk, arst_n, out_valid,
		frac_denominator != 17'd0 && frac_numerator <= frac_denominator)

endmodule

bind decimal_to_best_fraction dtbf_chk u_dtbf_chk (.*);

// File: tb/sv/tb_decimal_to_best_fraction.sv
// Testbench for decimal_to_best_fraction: signed Q32.32 to whole part plus best fraction.
// Depends on the RTL top level only; the expected results come from a local predictor.
`timescale 1ns / 1ps

module tb_decimal_to_best_fraction;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] whole_part;
	logic [16:0] frac_numerator;
	logic [16:0] frac_denominator;
	logic        tolerance_we;
	logic [31:0] tolerance_wdata;

	typedef struct packed {
		logic [31:0] whole;
		logic [16:0] num;
		logic [16:0] den;
	} frac_res_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 3000;

	logic [63:0] pending_values[$];
	frac_res_t   expected_fracs[$];
	logic [31:0] tol_model;
	int          mismatches;
	int          idle_cycles;
	int          in_gap;
	int          out_gap;
	bit          timed_out;

	decimal_to_best_fraction u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.whole_part(whole_part),
		.frac_numerator(frac_numerator),
		.frac_denominator(frac_denominator),
		.tolerance_we(tolerance_we),
		.tolerance_wdata(tolerance_wdata)
	);

	// clock, 8 ns period
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// mostly short gaps, a few long ones, some runs with none
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 60);
	endfunction

	// best-fraction search, exact integer arithmetic
	function automatic frac_res_t best_fraction(logic [63:0] raw, logic [31:0] tol);
		frac_res_t   res;
		bit          neg;
		logic [63:0] mag;
		logic [63:0] frac;
		longint      rem;
		longint      tl;
		longint      t_lo;
		longint      t_hi;
		longint      lo_n;
		longint      lo_d;
		longint      hi_n;
		longint      hi_d;
		longint      cnt;
		longint      nn;
		longint      dd;
		lo_n = 0;
		lo_d = 1;
		hi_n = 1;
		hi_d = 1;
		neg = raw[63];
		mag = neg ? (64'd0 - raw) : raw;
		frac = {32'd0, mag[31:0]};
		res.whole = neg ? (32'd0 - mag[63:32]) : mag[63:32];
		if (neg && frac != 0) begin
			res.num = 17'd0;
			res.den = 17'd1;
			return res;
		end
		rem = longint'(frac);
		tl = longint'({32'd0, tol});
		for (int i = 0; i < 100; i++) begin
			t_lo = lo_d * rem - (lo_n <<< 32);
			t_hi = (hi_n <<< 32) - hi_d * rem;
			if (t_hi < tl * hi_d)
				break;
			if (t_lo < tl * lo_d) begin
				hi_n = lo_n;
				hi_d = lo_d;
				break;
			end
			if (i % 2 == 1) begin
				if (t_lo == 0)
					break;
				cnt = t_hi / t_lo;
				if (cnt > 65536)
					break;
				nn = (cnt + 1) * lo_n + hi_n;
				dd = (cnt + 1) * lo_d + hi_d;
				if (nn > 32768 || dd > 65536)
					break;
				hi_n = nn - lo_n;
				hi_d = dd - lo_d;
				lo_n = nn;
				lo_d = dd;
			end else begin
				if (t_hi == 0)
					break;
				cnt = t_lo / t_hi;
				if (cnt > 65536)
					break;
				nn = lo_n + (cnt + 1) * hi_n;
				dd = lo_d + (cnt + 1) * hi_d;
				if (nn > 65536 || dd > 65536)
					break;
				lo_n = nn - hi_n;
				lo_d = dd - hi_d;
				hi_n = nn;
				hi_d = dd;
			end
		end
		res.num = hi_n[16:0];
		res.den = hi_d[16:0];
		return res;
	endfunction

	// random value, biased toward simple and near-simple fractions
	function automatic logic [63:0] rand_value();
		logic [31:0] fr;
		logic [31:0] wh;
		int          d;
		int          n;
		int          k;
		wh = $urandom();
		k = $urandom_range(0, 9);
		if (k < 4) begin
			d = $urandom_range(1, 400);
			n = $urandom_range(0, d - 1);
			fr = 32'(({32'd0, 32'(n)} << 32) / 64'(d));
			if ($urandom_range(0, 1))
				fr = fr + 32'($urandom_range(0, 15)) - 32'd7;
		end else if (k < 6) begin
			wh = 32'($signed($urandom_range(0, 20)) - 10);
			fr = $urandom();
		end else begin
			fr = $urandom();
		end
		return {wh, fr};
	endfunction

	// wait until every expected result is back and the block has settled
	task automatic drain();
		while (pending_values.size() != 0 || expected_fracs.size() != 0 || in_valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [31:0] tol);
		tolerance_we <= 1'b1;
		tolerance_wdata <= tol;
		@(posedge clk);
		tolerance_we <= 1'b0;
		tol_model = tol;
		@(posedge clk);
	endtask

	// stimulus phases
	initial begin
		logic [31:0] tols[6];
		tols = '{32'd1, 32'hFFFF_FFFF, 32'd65536, 32'd4295, 32'd1000000, 32'h0100_0000};
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = 64'd0;
		out_stall = 1'b0;
		tolerance_we = 1'b0;
		tolerance_wdata = 32'd0;
		tol_model = 32'd4295;
		mismatches = 0;
		timed_out = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, negative remainders, exact fractions, near-misses
		pending_values.push_back(64'h0000_0000_0000_0000);
		pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
		pending_values.push_back(64'h8000_0000_0000_0000);
		pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		pending_values.push_back(64'hFFFF_FFFF_0000_0000);
		pending_values.push_back(64'h0000_0001_8000_0000);
		pending_values.push_back(64'hFFFF_FFFE_8000_0000);
		pending_values.push_back(64'h0000_0000_5555_5555);
		pending_values.push_back(64'h0000_0000_AAAA_AAAB);
		pending_values.push_back(64'h0000_0000_0000_0001);
		pending_values.push_back(64'h0000_0000_FFFF_FFFF);
		pending_values.push_back(64'h0000_0003_243F_6A88);
		pending_values.push_back(64'h0000_0002_B7E1_5162);
		pending_values.push_back(64'h0000_0000_0001_0000);
		pending_values.push_back(64'h0000_0000_0000_8000);
		pending_values.push_back(64'h0000_0000_9E37_79B9);
		pending_values.push_back(64'h1234_5678_4000_0000);
		drain();

		// random phases across tolerance settings, extremes included
		for (int p = 0; p < 6; p++) begin
			write_tolerance(tols[p]);
			for (int j = 0; j < 108; j++)
				pending_values.push_back(rand_value());
			drain();
		end

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// input driver; prediction made on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_fracs.push_back(best_fraction(value, tol_model));
				in_gap = pick_gap();
				if (in_gap == 0 && pending_values.size() != 0 && !tolerance_we) begin
					value <= pending_values.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end else if (!in_valid) begin
				if (in_gap > 0)
					in_gap--;
				else if (pending_values.size() != 0 && !tolerance_we) begin
					value <= pending_values.pop_front();
					in_valid <= 1'b1;
				end
			end
		end else begin
			in_gap = 0;
		end
	end

	// output monitor with random stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_fracs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: whole=%0d num=%0d den=%0d",
							$signed(whole_part), frac_numerator, frac_denominator);
				end else begin
					frac_res_t e;
					e = expected_fracs.pop_front();
					if (e.whole !== whole_part || e.num !== frac_numerator ||
						e.den !== frac_denominator) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %0d %0d/%0d got %0d %0d/%0d",
								$signed(e.whole), e.num, e.den, $signed(whole_part),
								frac_numerator, frac_denominator);
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_gap = pick_gap();
				out_stall <= (out_gap != 0);
			end
		end else begin
			out_gap = 0;
		end
	end

	// watchdog on cycles with no item accepted on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("DONE: errors detected");
			$finish;
		end
	end

	// idle count starts at zero before the first clock edge
	initial idle_cycles = 0;

endmodule

// File: filelist.f
+incdir+hdl
hdl/dtbf_pkg.sv
hdl/dtbf_mul.sv
hdl/dtbf_div.sv
hdl/decimal_to_best_fraction.sv
hdl/dtbf_chk.sv
tb/sv/tb_decimal_to_best_fraction.sv
